// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When the antecedent holds, the consequent must hold in the same cycle.
`define TCF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define TCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tcf_pkg.sv -----
package tcf_pkg;

  // Fixed field widths.
  localparam int CHANNELS = 6;
  localparam int PWM_W    = 16;
  localparam int LIGHT_W  = 11;
  localparam int STEP_W   = 10;
  localparam int TIME_W   = 32;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;

  // Light limits and button codes.
  localparam logic [LIGHT_W-1:0] LIGHT_LOW     = 11'd1000;
  localparam logic [LIGHT_W-1:0] LIGHT_HIGH    = 11'd2000;
  localparam logic [PWM_W-1:0]   BUTTON_DIM    = 16'd1000;
  localparam logic [PWM_W-1:0]   BUTTON_BRIGHT = 16'd2000;

  // Register reset values.
  localparam logic [PWM_W-1:0]  PWM_MIN_RST     = 16'd1100;
  localparam logic [PWM_W-1:0]  PWM_MAX_RST     = 16'd1900;
  localparam logic [PWM_W-1:0]  PWM_NEUTRAL_RST = 16'd1500;
  localparam logic [STEP_W-1:0] LAMP_INCR_RST   = 10'd100;
  localparam logic [TIME_W-1:0] MAX_GAP_RST     = 32'd1000;

  typedef enum logic [1:0] {
    MODE_MOTOR = 2'd0,
    MODE_ARM   = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ACT_DISARM    = 2'd0,
    ACT_ARM       = 2'd1,
    ACT_OTHER_ARG = 2'd2,
    ACT_OTHER_CMD = 2'd3
  } arm_act_t;

  typedef enum logic [2:0] {
    REG_PWM_MIN     = 3'd0,
    REG_PWM_MAX     = 3'd1,
    REG_PWM_NEUTRAL = 3'd2,
    REG_LAMP_INCR   = 3'd3,
    REG_MAX_GAP     = 3'd4
  } reg_idx_t;

  // One accepted command as held in the input register.
  typedef struct packed {
    mode_t                            mode;
    logic [TIME_W-1:0]                now_ms;
    logic [CHANNELS-1:0][PWM_W-1:0]   chan_pwm;
    logic [PWM_W-1:0]                 light_button;
    arm_act_t                         arm_action;
  } in_item_t;

endpackage

// ----- sv/tcf_in_if.sv -----
interface tcf_in_if import tcf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [TIME_W-1:0] now_ms;
  logic [PWM_W-1:0]  chan_pwm_0;
  logic [PWM_W-1:0]  chan_pwm_1;
  logic [PWM_W-1:0]  chan_pwm_2;
  logic [PWM_W-1:0]  chan_pwm_3;
  logic [PWM_W-1:0]  chan_pwm_4;
  logic [PWM_W-1:0]  chan_pwm_5;
  logic [PWM_W-1:0]  light_button;
  logic [1:0]        arm_action;

  modport source (
    output valid, mode, now_ms, chan_pwm_0, chan_pwm_1, chan_pwm_2, chan_pwm_3,
           chan_pwm_4, chan_pwm_5, light_button, arm_action,
    input  ready
  );

  modport sink (
    input  valid, mode, now_ms, chan_pwm_0, chan_pwm_1, chan_pwm_2, chan_pwm_3,
           chan_pwm_4, chan_pwm_5, light_button, arm_action,
    output ready
  );
endinterface

// ----- sv/tcf_out_if.sv -----
interface tcf_out_if import tcf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PWM_W-1:0]   motor_out_0;
  logic [PWM_W-1:0]   motor_out_1;
  logic [PWM_W-1:0]   motor_out_2;
  logic [PWM_W-1:0]   motor_out_3;
  logic [PWM_W-1:0]   motor_out_4;
  logic [PWM_W-1:0]   motor_out_5;
  logic [LIGHT_W-1:0] light_out;
  logic               override_ok;
  logic               command_status;
  logic               armed_out;

  modport source (
    output valid, motor_out_0, motor_out_1, motor_out_2, motor_out_3, motor_out_4,
           motor_out_5, light_out, override_ok, command_status, armed_out,
    input  ready
  );

  modport sink (
    input  valid, motor_out_0, motor_out_1, motor_out_2, motor_out_3, motor_out_4,
           motor_out_5, light_out, override_ok, command_status, armed_out,
    output ready
  );
endinterface

// ----- sv/thruster_command_failsafe_unit.sv -----
// Thruster command failsafe.
// Commands arrive on in_ch with a valid/ready handshake: a motor packet
// (six pulse widths and a light button), an arm or disarm command, or a
// watchdog tick carrying the millisecond clock. Every command produces one
// result transfer on out_ch with the motor levels, light level, armed flag
// and the status bits of that command.
// A command is held in the input register and its result is registered in
// the result register, from which it is offered on out_ch. One command per
// cycle is sustained while out_ch is not stalled; the compare chain over the
// six channels and the state update are combinational between the registers.
// While out_ch is stalled, the input register still takes one more command;
// after that in_ch.ready drops until the result is taken.
// Reset (rst_n low, synchronous) empties both registers, disarms, sets the
// motors to the reset neutral width, the light to its lowest level, the
// last good time to zero and the APB registers to their defaults.
// Registers at byte addresses 0, 4, 8, 12, 16: pwm_min, pwm_max,
// pwm_neutral, light step size, max_gap_ms; write them only while idle.
module thruster_command_failsafe_unit import tcf_pkg::*; #(
  parameter int MOTOR_COUNT = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  tcf_in_if.sink            in_ch,
  tcf_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  // Configuration registers.
  logic [PWM_W-1:0]  pwm_min_r;
  logic [PWM_W-1:0]  pwm_max_r;
  logic [PWM_W-1:0]  pwm_neutral_r;
  logic [STEP_W-1:0] lamp_incr_r;
  logic [TIME_W-1:0] max_gap_r;
  reg_idx_t          reg_sel;
  logic              cfg_wr;

  // Input stage and result stage.
  logic     s1_valid_r;
  in_item_t s1_item_r;
  in_item_t in_item;
  logic     out_valid_r;
  logic     advance;
  logic     ok_r, ok_nxt;
  logic     status_r, status_nxt;

  // Block state.
  logic [PWM_W-1:0]   motor_r   [MOTOR_COUNT];
  logic [PWM_W-1:0]   motor_nxt [MOTOR_COUNT];
  logic               armed_r, armed_nxt;
  logic [TIME_W-1:0]  last_good_r, last_good_nxt;
  logic [LIGHT_W-1:0] light_r, light_nxt;
  logic [PWM_W-1:0]   motor_view [CHANNELS];

  // Working signals of the command logic.
  logic               chain_ok;
  logic               ch_ok;
  logic               any_on;
  logic [LIGHT_W-1:0] light_room_dn;
  logic [LIGHT_W-1:0] light_room_up;
  logic [TIME_W-1:0]  gap;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Register read-back.
  always_comb begin
    case (reg_sel)
      REG_PWM_MIN:     prdata = CFG_DW'(pwm_min_r);
      REG_PWM_MAX:     prdata = CFG_DW'(pwm_max_r);
      REG_PWM_NEUTRAL: prdata = CFG_DW'(pwm_neutral_r);
      REG_LAMP_INCR:   prdata = CFG_DW'(lamp_incr_r);
      REG_MAX_GAP:     prdata = CFG_DW'(max_gap_r);
      default:         prdata = '0;
    endcase
  end

  // Register writes; addresses past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_min_r     <= PWM_MIN_RST;
      pwm_max_r     <= PWM_MAX_RST;
      pwm_neutral_r <= PWM_NEUTRAL_RST;
      lamp_incr_r   <= LAMP_INCR_RST;
      max_gap_r     <= MAX_GAP_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_PWM_MIN:     pwm_min_r     <= pwdata[PWM_W-1:0];
        REG_PWM_MAX:     pwm_max_r     <= pwdata[PWM_W-1:0];
        REG_PWM_NEUTRAL: pwm_neutral_r <= pwdata[PWM_W-1:0];
        REG_LAMP_INCR:   lamp_incr_r   <= pwdata[STEP_W-1:0];
        REG_MAX_GAP:     max_gap_r     <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the result stage moves when its register is empty or taken.
  // No input transfer is taken while reset is held.
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = rst_n && (!s1_valid_r || advance);

  always_comb begin
    in_item.mode         = mode_t'(in_ch.mode);
    in_item.now_ms       = in_ch.now_ms;
    in_item.chan_pwm[0]  = in_ch.chan_pwm_0;
    in_item.chan_pwm[1]  = in_ch.chan_pwm_1;
    in_item.chan_pwm[2]  = in_ch.chan_pwm_2;
    in_item.chan_pwm[3]  = in_ch.chan_pwm_3;
    in_item.chan_pwm[4]  = in_ch.chan_pwm_4;
    in_item.chan_pwm[5]  = in_ch.chan_pwm_5;
    in_item.light_button = in_ch.light_button;
    in_item.arm_action   = arm_act_t'(in_ch.arm_action);
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r <= in_item;
    end
  end

  // Light room below and above the current level.
  assign light_room_dn = light_r - LIGHT_LOW;
  assign light_room_up = LIGHT_HIGH - light_r;
  assign gap           = s1_item_r.now_ms - last_good_r;

  always_comb begin
    any_on = 1'b0;
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      any_on = any_on || (motor_r[i] != pwm_neutral_r);
    end
  end

  // Command logic: next state and status bits for the held command.
  always_comb begin
    motor_nxt     = motor_r;
    armed_nxt     = armed_r;
    last_good_nxt = last_good_r;
    light_nxt     = light_r;
    ok_nxt        = 1'b0;
    status_nxt    = 1'b0;
    chain_ok      = 1'b1;
    ch_ok         = 1'b0;
    case (s1_item_r.mode)
      MODE_MOTOR: begin
        // Channels are written in order until the first rejected one.
        for (int i = 0; i < MOTOR_COUNT; i++) begin
          ch_ok = armed_r && (s1_item_r.chan_pwm[i] >= pwm_min_r) &&
                  (s1_item_r.chan_pwm[i] <= pwm_max_r);
          if (chain_ok && ch_ok) begin
            motor_nxt[i] = s1_item_r.chan_pwm[i];
          end
          chain_ok = chain_ok && ch_ok;
        end
        if (MOTOR_COUNT < CHANNELS) begin
          chain_ok = 1'b0;
        end
        // The light steps whether or not the motors were accepted.
        if (s1_item_r.light_button == BUTTON_DIM) begin
          light_nxt = (LIGHT_W'(lamp_incr_r) > light_room_dn) ? LIGHT_LOW
                                                             : light_r - LIGHT_W'(lamp_incr_r);
        end else if (s1_item_r.light_button == BUTTON_BRIGHT) begin
          light_nxt = (LIGHT_W'(lamp_incr_r) > light_room_up) ? LIGHT_HIGH
                                                             : light_r + LIGHT_W'(lamp_incr_r);
        end
        if (chain_ok) begin
          last_good_nxt = s1_item_r.now_ms;
          ok_nxt        = 1'b1;
        end
      end
      MODE_ARM: begin
        case (s1_item_r.arm_action)
          ACT_ARM: armed_nxt = 1'b1;
          ACT_DISARM: begin
            if (armed_r) begin
              for (int i = 0; i < MOTOR_COUNT; i++) begin
                motor_nxt[i] = pwm_neutral_r;
              end
              armed_nxt = 1'b0;
            end
          end
          default: status_nxt = 1'b1;
        endcase
      end
      MODE_TICK: begin
        // Clock went backwards, or the command gap is too long.
        if (s1_item_r.now_ms < last_good_r) begin
          last_good_nxt = s1_item_r.now_ms;
          for (int i = 0; i < MOTOR_COUNT; i++) begin
            motor_nxt[i] = pwm_neutral_r;
          end
        end else if (gap > max_gap_r) begin
          if (any_on) begin
            last_good_nxt = s1_item_r.now_ms;
          end
          for (int i = 0; i < MOTOR_COUNT; i++) begin
            motor_nxt[i] = pwm_neutral_r;
          end
        end
      end
      default: ;
    endcase
  end

  // State and result register; state only moves together with a result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ok_r        <= 1'b0;
      status_r    <= 1'b0;
      armed_r     <= 1'b0;
      last_good_r <= '0;
      light_r     <= LIGHT_LOW;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        motor_r[i] <= PWM_NEUTRAL_RST;
      end
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        ok_r        <= ok_nxt;
        status_r    <= status_nxt;
        armed_r     <= armed_nxt;
        last_good_r <= last_good_nxt;
        light_r     <= light_nxt;
        motor_r     <= motor_nxt;
      end
    end
  end

  // Motors past the configured count read as zero.
  for (genvar g = 0; g < CHANNELS; g++) begin : g_view
    if (g < MOTOR_COUNT) begin : g_used
      assign motor_view[g] = motor_r[g];
    end else begin : g_unused
      assign motor_view[g] = '0;
    end
  end

  // The state registers hold the last delivered values until the next result.
  assign out_ch.valid          = out_valid_r;
  assign out_ch.motor_out_0    = motor_view[0];
  assign out_ch.motor_out_1    = motor_view[1];
  assign out_ch.motor_out_2    = motor_view[2];
  assign out_ch.motor_out_3    = motor_view[3];
  assign out_ch.motor_out_4    = motor_view[4];
  assign out_ch.motor_out_5    = motor_view[5];
  assign out_ch.light_out      = light_r;
  assign out_ch.override_ok    = ok_r;
  assign out_ch.command_status = status_r;
  assign out_ch.armed_out      = armed_r;

endmodule

// ----- sv/tcf_checker.sv -----
`include "assert_macros.svh"

module tcf_checker import tcf_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [PWM_W-1:0]   motor_out_0,
  input logic [LIGHT_W-1:0] light_out,
  input logic               override_ok,
  input logic               command_status,
  input logic               armed_out
);

  // A stalled result transfer keeps its valid, light level, first motor output and override flag.
  `TCF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(light_out) && $stable(motor_out_0) && $stable(override_ok), "stalled result changed")

  // The light level never leaves its clamp range.
  `TCF_ASSERT_SAME(a_light_range, out_valid, (light_out >= LIGHT_LOW) && (light_out <= LIGHT_HIGH), "light level out of range")

  // A fully accepted motor packet needs the block armed.
  `TCF_ASSERT_SAME(a_ok_armed, out_valid && override_ok, armed_out, "override accepted while disarmed")

  // A result carries the status of one command kind only.
  `TCF_ASSERT_SAME(a_status_excl, out_valid, !(override_ok && command_status), "override and arm status both set")

endmodule

bind thruster_command_failsafe_unit tcf_checker u_tcf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .motor_out_0    (out_ch.motor_out_0),
  .light_out      (out_ch.light_out),
  .override_ok    (out_ch.override_ok),
  .command_status (out_ch.command_status),
  .armed_out      (out_ch.armed_out)
);
